/* src/rtts_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, codes and types for the room thermal step block.
// Used by rtts_cfg, rtts_mul, room_two_state_thermal_step and the testbench; depends on nothing.
package rtts_pkg;

	localparam int CFG_W      = 32;
	localparam int IDX_W      = 3;
	localparam int NUM_REGS   = 8;
	localparam int OP_A_W     = 50;
	localparam int OP_B_W     = 33;
	localparam int PROD_W     = 48;
	localparam int IN_DATA_W  = 112;
	localparam int OUT_DATA_W = 32;

	typedef enum logic [IDX_W-1:0] {
		CFG_AIR_CP       = 3'd0,
		CFG_CONV_GAIN    = 3'd1,
		CFG_HEAT_BIAS    = 3'd2,
		CFG_INV_AIR_CAP  = 3'd3,
		CFG_INV_WALL_CAP = 3'd4,
		CFG_INV_R_INNER  = 3'd5,
		CFG_INV_R_OUTER  = 3'd6,
		CFG_INNER_RATIO  = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		SH_4  = 2'd0,
		SH_10 = 2'd1,
		SH_16 = 2'd2
	} shift_sel_t;

	typedef struct packed {
		logic       start;
		shift_sel_t shift;
	} mul_req_t;

	typedef struct packed {
		logic [CFG_W-1:0]        air_heat_capacity;
		logic [CFG_W-1:0]        convective_gain;
		logic signed [CFG_W-1:0] heat_bias;
		logic [CFG_W-1:0]        inv_air_capacitance;
		logic [CFG_W-1:0]        inv_wall_capacitance;
		logic [CFG_W-1:0]        inv_inner_resistance;
		logic [CFG_W-1:0]        inv_outer_resistance;
		logic [CFG_W-1:0]        inner_to_total_ratio;
	} cfg_t;

endpackage

/* src/rtts_cfg.sv */
`timescale 1ns / 1ps
// Configuration register file of the room thermal step block.
// Depends on rtts_pkg for the register indexes and the cfg_t bundle.
module rtts_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [rtts_pkg::IDX_W-1:0]  wr_index,
	input  logic [rtts_pkg::CFG_W-1:0]  wr_data,
	output rtts_pkg::cfg_t              cfg
);
	import rtts_pkg::*;

	localparam logic [CFG_W-1:0] AIR_CP_RESET = 32'd15729;

	logic [CFG_W-1:0] regs_q [NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= (i == int'(CFG_AIR_CP)) ? AIR_CP_RESET : '0;
			end
		end else if (wr_en) begin
			regs_q[wr_index] <= wr_data;
		end
	end

	always_comb begin
		cfg.air_heat_capacity    = regs_q[CFG_AIR_CP];
		cfg.convective_gain      = regs_q[CFG_CONV_GAIN];
		cfg.heat_bias            = $signed(regs_q[CFG_HEAT_BIAS]);
		cfg.inv_air_capacitance  = regs_q[CFG_INV_AIR_CAP];
		cfg.inv_wall_capacitance = regs_q[CFG_INV_WALL_CAP];
		cfg.inv_inner_resistance = regs_q[CFG_INV_R_INNER];
		cfg.inv_outer_resistance = regs_q[CFG_INV_R_OUTER];
		cfg.inner_to_total_ratio = regs_q[CFG_INNER_RATIO];
	end

endmodule

/* src/rtts_mul.sv */
`timescale 1ns / 1ps
// Shared multi-cycle signed multiplier with floor shift and saturation.
// Depends on rtts_pkg; one 25 by 33 bit multiplier serves both halves of operand A.
module rtts_mul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rtts_pkg::mul_req_t                  req,
	input  logic signed [rtts_pkg::OP_A_W-1:0]  op_a,
	input  logic signed [rtts_pkg::OP_B_W-1:0]  op_b,
	output logic signed [rtts_pkg::PROD_W-1:0]  result,
	output logic                                done
);
	import rtts_pkg::*;

	localparam int HALF_W = OP_A_W / 2;
	localparam int PP_W   = HALF_W + OP_B_W;
	localparam int ACC_W  = OP_A_W + OP_B_W;
	localparam int MAG_W  = 63;
	localparam logic [ACC_W-1:0] SAT_LIM = ACC_W'(1) << (MAG_W - 1);
	localparam logic signed [PROD_W-1:0] PROD_LIM = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [MAG_W:0] LIM_WIDE = (MAG_W + 1)'(PROD_LIM);

	typedef enum logic [4:0] {
		U_IDLE = 5'b00001,
		U_LO   = 5'b00010,
		U_HI   = 5'b00100,
		U_SGN  = 5'b01000,
		U_SHF  = 5'b10000
	} mul_state_t;

	mul_state_t               state_q;
	logic                     done_q;
	logic [OP_A_W-1:0]        ua_q;
	logic [OP_B_W-1:0]        ub_q;
	logic                     neg_q;
	shift_sel_t               shift_q;
	logic [ACC_W-1:0]         acc_q;
	logic                     sat_q;
	logic signed [MAG_W:0]    sp_q;
	logic signed [PROD_W-1:0] result_q;

	logic [OP_A_W-1:0]        a_mag;
	logic [OP_B_W-1:0]        b_mag;
	logic [HALF_W-1:0]        mul_a;
	logic [PP_W-1:0]          pp;
	logic signed [MAG_W:0]    mag_s;
	logic signed [MAG_W:0]    shifted;
	logic signed [PROD_W-1:0] clamped;

	assign a_mag = op_a[OP_A_W-1] ? OP_A_W'(-op_a) : OP_A_W'(op_a);
	assign b_mag = op_b[OP_B_W-1] ? OP_B_W'(-op_b) : OP_B_W'(op_b);

	assign mul_a = (state_q == U_HI) ? ua_q[OP_A_W-1:HALF_W] : ua_q[HALF_W-1:0];
	assign pp    = {{OP_B_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, ub_q};
	assign mag_s = $signed({1'b0, acc_q[MAG_W-1:0]});

	always_comb begin
		case (shift_q)
			SH_4:    shifted = sp_q >>> 4;
			SH_10:   shifted = sp_q >>> 10;
			SH_16:   shifted = sp_q >>> 16;
			default: shifted = sp_q >>> 16;
		endcase
		if (shifted > LIM_WIDE) begin
			clamped = PROD_LIM;
		end else if (shifted < -LIM_WIDE) begin
			clamped = -PROD_LIM;
		end else begin
			clamped = PROD_W'(shifted);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				U_IDLE: begin
					if (req.start) begin
						state_q <= U_LO;
					end
				end
				U_LO:  state_q <= U_HI;
				U_HI:  state_q <= U_SGN;
				U_SGN: state_q <= U_SHF;
				U_SHF: begin
					state_q <= U_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= U_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			U_IDLE: begin
				if (req.start) begin
					ua_q    <= a_mag;
					ub_q    <= b_mag;
					neg_q   <= op_a[OP_A_W-1] ^ op_b[OP_B_W-1];
					shift_q <= req.shift;
				end
			end
			U_LO: acc_q <= ACC_W'(pp);
			U_HI: acc_q <= acc_q + (ACC_W'(pp) << HALF_W);
			U_SGN: begin
				sat_q <= acc_q > SAT_LIM;
				sp_q  <= neg_q ? -mag_s : mag_s;
			end
			U_SHF: begin
				if (sat_q) begin
					result_q <= neg_q ? -PROD_LIM : PROD_LIM;
				end else begin
					result_q <= clamped;
				end
			end
			default: acc_q <= acc_q;
		endcase
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

/* src/room_two_state_thermal_step.sv */
`timescale 1ns / 1ps
// Top level of the two-state room thermal step: sequencer, state and stream ports.
// Depends on rtts_pkg, rtts_cfg and rtts_mul.
//
// Each request on the input stream advances the room air and wall temperatures by one
// explicit Euler tick and produces one result with both temperatures in 1/256 F, clamped
// to -40..120 F. All products run one after another through a single shared multiplier.
// A normal tick has nine products and a restart tick has eight. The input is not ready
// until the result of the tick has been placed in the output register, so a new request
// is taken only once the previous tick is through, and an output stall holds it back.
// The next request is taken while the previous result still waits in the output register.
// Configuration writes are taken at any time and must be made while the block is idle.
module room_two_state_thermal_step (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// step_time[15:0], duct_supply_temp[31:16], mass_flow[51:32], outside_temp[67:52],
	// other_heat[88:68], setpoint_temp[104:89], zero fill[111:105]
	input  logic [rtts_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// restart[0]
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// room_air_temp[15:0], wall_temp[31:16]
	output logic [rtts_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rtts_pkg::IDX_W-1:0]          cfg_index,
	input  logic [rtts_pkg::CFG_W-1:0]          cfg_data
);
	import rtts_pkg::*;

	localparam int TEMP_W = 25;
	localparam int WALL_W = 42;
	localparam logic signed [TEMP_W-1:0] T_MIN = -25'sd2621440;
	localparam logic signed [TEMP_W-1:0] T_MAX = 25'sd7864320;
	localparam logic signed [PROD_W:0] T_MIN_X = (PROD_W + 1)'(T_MIN);
	localparam logic signed [PROD_W:0] T_MAX_X = (PROD_W + 1)'(T_MAX);

	typedef enum logic [11:0] {
		S_IDLE  = 12'h001,
		S_WRST  = 12'h002,
		S_AIRG  = 12'h004,
		S_QFLOW = 12'h008,
		S_QWI   = 12'h010,
		S_QWO   = 12'h020,
		S_QC    = 12'h040,
		S_TADOT = 12'h080,
		S_TWDOT = 12'h100,
		S_DA    = 12'h200,
		S_DW    = 12'h400,
		S_OUT   = 12'h800
	} seq_state_t;

	typedef struct packed {
		logic [15:0]        step_time;
		logic signed [15:0] duct_supply_temp;
		logic [19:0]        mass_flow;
		logic signed [15:0] outside_temp;
		logic signed [20:0] other_heat;
		logic signed [15:0] setpoint_temp;
	} item_t;

	function automatic logic signed [TEMP_W-1:0] sat_temp(input logic signed [PROD_W:0] v);
		return (v < T_MIN_X) ? T_MIN : ((v > T_MAX_X) ? T_MAX : TEMP_W'(v));
	endfunction

	cfg_t                     cfg;
	mul_req_t                 mul_req;
	logic signed [OP_A_W-1:0] op_a;
	logic signed [OP_B_W-1:0] op_b;
	logic signed [PROD_W-1:0] mul_res;
	logic                     mul_done;

	seq_state_t               state_q;
	logic                     go_q;
	logic                     out_valid_q;
	logic [OUT_DATA_W-1:0]    out_data_q;
	logic signed [TEMP_W-1:0] ta_q;
	logic signed [WALL_W-1:0] tw_q;
	item_t                    item_q;
	logic signed [PROD_W-1:0] qflow_q;
	logic signed [PROD_W-1:0] qwi_q;
	logic signed [PROD_W-1:0] qwo_q;
	logic signed [OP_A_W-1:0] qnet_q;
	logic signed [PROD_W-1:0] tadot_q;
	logic signed [PROD_W-1:0] twdot_q;

	logic signed [TEMP_W-1:0] tset_w;
	logic signed [TEMP_W-1:0] tout_w;
	logic signed [TEMP_W-1:0] tduct_w;
	logic signed [32:0]       qother_w;
	logic signed [TEMP_W:0]   set_out_diff;
	logic signed [TEMP_W:0]   duct_air_diff;
	logic signed [WALL_W:0]   air_wall_diff;
	logic signed [WALL_W:0]   wall_out_diff;
	logic signed [PROD_W:0]   qwi_qwo_diff;
	logic signed [OP_A_W-1:0] qnet_d;
	logic signed [WALL_W-1:0] wall_rst_d;
	logic signed [WALL_W-1:0] wall_init;
	logic signed [PROD_W:0]   air_sum;
	logic signed [PROD_W:0]   wall_sum;
	logic                     out_free;

	rtts_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	rtts_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.op_a   (op_a),
		.op_b   (op_b),
		.result (mul_res),
		.done   (mul_done)
	);

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign out_free      = !out_valid_q || m_axis_tready;

	assign tset_w   = TEMP_W'($signed({item_q.setpoint_temp, 8'h00}));
	assign tout_w   = TEMP_W'($signed({item_q.outside_temp, 8'h00}));
	assign tduct_w  = TEMP_W'($signed({item_q.duct_supply_temp, 8'h00}));
	assign qother_w = $signed({item_q.other_heat, 12'h000});

	assign set_out_diff  = (TEMP_W + 1)'(tset_w) - (TEMP_W + 1)'(tout_w);
	assign duct_air_diff = (TEMP_W + 1)'(tduct_w) - (TEMP_W + 1)'(ta_q);
	assign air_wall_diff = (WALL_W + 1)'(ta_q) - (WALL_W + 1)'(tw_q);
	assign wall_out_diff = (WALL_W + 1)'(tw_q) - (WALL_W + 1)'(tout_w);
	assign qwi_qwo_diff  = (PROD_W + 1)'(qwi_q) - (PROD_W + 1)'(qwo_q);

	assign qnet_d = OP_A_W'(qflow_q) - OP_A_W'(qwi_q) + OP_A_W'($signed(cfg.heat_bias))
	              - OP_A_W'(mul_res) + OP_A_W'(qother_w);

	assign wall_rst_d = WALL_W'(tset_w) - WALL_W'(mul_res);
	assign wall_init  = (wall_rst_d < WALL_W'(tout_w)) ? WALL_W'(tout_w) : wall_rst_d;

	assign air_sum  = (PROD_W + 1)'(ta_q) + (PROD_W + 1)'(mul_res);
	assign wall_sum = (PROD_W + 1)'(tw_q) + (PROD_W + 1)'(mul_res);

	always_comb begin
		mul_req.start = go_q;
		mul_req.shift = SH_16;
		op_a          = '0;
		op_b          = '0;
		case (state_q)
			S_WRST: begin
				op_a = OP_A_W'(set_out_diff);
				op_b = OP_B_W'(cfg.inner_to_total_ratio);
			end
			S_AIRG: begin
				op_a          = OP_A_W'(cfg.air_heat_capacity);
				op_b          = OP_B_W'(item_q.mass_flow);
				mul_req.shift = SH_4;
			end
			S_QFLOW: begin
				op_a = OP_A_W'(qflow_q);
				op_b = OP_B_W'(duct_air_diff);
			end
			S_QWI: begin
				op_a = OP_A_W'(air_wall_diff);
				op_b = OP_B_W'(cfg.inv_inner_resistance);
			end
			S_QWO: begin
				op_a = OP_A_W'(wall_out_diff);
				op_b = OP_B_W'(cfg.inv_outer_resistance);
			end
			S_QC: begin
				op_a = OP_A_W'(cfg.convective_gain);
				op_b = OP_B_W'(ta_q);
			end
			S_TADOT: begin
				op_a = qnet_q;
				op_b = OP_B_W'(cfg.inv_air_capacitance);
			end
			S_TWDOT: begin
				op_a = OP_A_W'(qwi_qwo_diff);
				op_b = OP_B_W'(cfg.inv_wall_capacitance);
			end
			S_DA: begin
				op_a          = OP_A_W'(tadot_q);
				op_b          = OP_B_W'(item_q.step_time);
				mul_req.shift = SH_10;
			end
			S_DW: begin
				op_a          = OP_A_W'(twdot_q);
				op_b          = OP_B_W'(item_q.step_time);
				mul_req.shift = SH_10;
			end
			default: op_a = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			go_q        <= 1'b0;
			out_valid_q <= 1'b0;
			ta_q        <= '0;
			tw_q        <= '0;
		end else begin
			go_q <= 1'b0;
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= s_axis_tuser ? S_WRST : S_AIRG;
						go_q    <= 1'b1;
					end
				end
				S_WRST: begin
					if (mul_done) begin
						ta_q    <= tset_w;
						tw_q    <= wall_init;
						state_q <= S_QWI;
						go_q    <= 1'b1;
					end
				end
				S_AIRG: begin
					if (mul_done) begin
						state_q <= S_QFLOW;
						go_q    <= 1'b1;
					end
				end
				S_QFLOW: begin
					if (mul_done) begin
						state_q <= S_QWI;
						go_q    <= 1'b1;
					end
				end
				S_QWI: begin
					if (mul_done) begin
						state_q <= S_QWO;
						go_q    <= 1'b1;
					end
				end
				S_QWO: begin
					if (mul_done) begin
						state_q <= S_QC;
						go_q    <= 1'b1;
					end
				end
				S_QC: begin
					if (mul_done) begin
						state_q <= S_TADOT;
						go_q    <= 1'b1;
					end
				end
				S_TADOT: begin
					if (mul_done) begin
						state_q <= S_TWDOT;
						go_q    <= 1'b1;
					end
				end
				S_TWDOT: begin
					if (mul_done) begin
						state_q <= S_DA;
						go_q    <= 1'b1;
					end
				end
				S_DA: begin
					if (mul_done) begin
						ta_q    <= sat_temp(air_sum);
						state_q <= S_DW;
						go_q    <= 1'b1;
					end
				end
				S_DW: begin
					if (mul_done) begin
						tw_q    <= WALL_W'(sat_temp(wall_sum));
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					item_q.step_time        <= s_axis_tdata[15:0];
					item_q.duct_supply_temp <= s_axis_tdata[31:16];
					item_q.mass_flow        <= s_axis_tdata[51:32];
					item_q.outside_temp     <= s_axis_tdata[67:52];
					item_q.other_heat       <= s_axis_tdata[88:68];
					item_q.setpoint_temp    <= s_axis_tdata[104:89];
				end
			end
			S_WRST: begin
				if (mul_done) begin
					qflow_q <= '0;
				end
			end
			S_AIRG, S_QFLOW: begin
				if (mul_done) begin
					qflow_q <= mul_res;
				end
			end
			S_QWI: begin
				if (mul_done) begin
					qwi_q <= mul_res;
				end
			end
			S_QWO: begin
				if (mul_done) begin
					qwo_q <= mul_res;
				end
			end
			S_QC: begin
				if (mul_done) begin
					qnet_q <= qnet_d;
				end
			end
			S_TADOT: begin
				if (mul_done) begin
					tadot_q <= mul_res;
				end
			end
			S_TWDOT: begin
				if (mul_done) begin
					twdot_q <= mul_res;
				end
			end
			S_OUT: begin
				if (out_free) begin
					out_data_q <= {tw_q[23:8], ta_q[23:8]};
				end
			end
			default: qflow_q <= qflow_q;
		endcase
	end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for room_two_state_thermal_step: drives tick requests and
// register writes, predicts air and wall temperatures in fixed point, and checks results.
// Depends on rtts_pkg and the block under test.
module testbench;
	import rtts_pkg::*;

	localparam int unsigned RUN_LIMIT = 400000;
	localparam int          IDLE_PCT  = 35;
	localparam longint      PROD_SAT  = (64'sd1 <<< 47) - 1;
	localparam longint      TEMP_LO   = -40 * 65536;
	localparam longint      TEMP_HI   = 120 * 65536;

	typedef struct {
		logic               restart;
		logic [15:0]        step_time;
		logic signed [15:0] duct_supply_temp;
		logic [19:0]        mass_flow;
		logic signed [15:0] outside_temp;
		logic signed [20:0] other_heat;
		logic signed [15:0] setpoint_temp;
	} tick_req_t;

	typedef struct {
		logic signed [15:0] room_air_temp;
		logic signed [15:0] wall_temp;
	} room_temps_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [IDX_W-1:0]      cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data = '0;

	logic [CFG_W-1:0] cfg_regs [NUM_REGS];
	logic [CFG_W-1:0] cfg_plan [NUM_REGS];
	longint           air_q16 = 0;
	longint           wall_q16 = 0;
	room_temps_t      temps_due [$];
	room_temps_t      oldest;
	bit               idle_on = 1'b1;
	int               errors = 0;
	int unsigned      cycle_count = 0;

	room_two_state_thermal_step u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count == RUN_LIMIT);
		$display("FAIL room_two_state_thermal_step");
		$finish;
	end

	function automatic longint clamp_q16(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Floor of a * b / 2^sh, saturated to the 48-bit product range.
	function automatic longint scaled_mul(longint a, longint b, int unsigned sh);
		bit         neg;
		bit [63:0]  ua;
		bit [63:0]  ub;
		bit [63:0]  p;
		longint     r;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		if (ua != 0 && ub > (64'd1 << 62) / ua)
			return neg ? -PROD_SAT : PROD_SAT;
		p = ua * ub;
		if (neg)
			r = -longint'((p + ((64'd1 << sh) - 1)) >> sh);
		else
			r = longint'(p >> sh);
		return clamp_q16(r, -PROD_SAT, PROD_SAT);
	endfunction

	function automatic room_temps_t advance_room(tick_req_t it);
		longint      dt, tduct, mdot, tout, qother, tset;
		longint      ta, tw, qflow, g, qwi, qwo, qconv, qnet, ta_dot, tw_dot;
		room_temps_t res;
		dt     = longint'(it.step_time);
		tduct  = longint'(it.duct_supply_temp) * 256;
		mdot   = longint'(it.mass_flow);
		tout   = longint'(it.outside_temp) * 256;
		qother = longint'(it.other_heat) * 4096;
		tset   = longint'(it.setpoint_temp) * 256;
		ta     = air_q16;
		tw     = wall_q16;
		qflow  = 0;
		if (it.restart) begin
			ta = tset;
			tw = tset - scaled_mul(tset - tout, longint'(cfg_regs[CFG_INNER_RATIO]), 16);
			if (tw < tout)
				tw = tout;
		end else begin
			g = scaled_mul(longint'(cfg_regs[CFG_AIR_CP]), mdot, 4);
			qflow = scaled_mul(g, tduct - ta, 16);
		end
		qwi = scaled_mul(ta - tw, longint'(cfg_regs[CFG_INV_R_INNER]), 16);
		qwo = scaled_mul(tw - tout, longint'(cfg_regs[CFG_INV_R_OUTER]), 16);
		qconv = longint'(signed'(cfg_regs[CFG_HEAT_BIAS]))
			- scaled_mul(longint'(cfg_regs[CFG_CONV_GAIN]), ta, 16);
		qnet = qflow - qwi + qconv + qother;
		ta_dot = scaled_mul(qnet, longint'(cfg_regs[CFG_INV_AIR_CAP]), 16);
		tw_dot = scaled_mul(qwi - qwo, longint'(cfg_regs[CFG_INV_WALL_CAP]), 16);
		ta = clamp_q16(ta + scaled_mul(ta_dot, dt, 10), TEMP_LO, TEMP_HI);
		tw = clamp_q16(tw + scaled_mul(tw_dot, dt, 10), TEMP_LO, TEMP_HI);
		air_q16  = ta;
		wall_q16 = tw;
		res.room_air_temp = 16'(ta >>> 8);
		res.wall_temp     = 16'(tw >>> 8);
		return res;
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (temps_due.size() == 0) begin
				$error("result %h arrived with no request pending", m_axis_tdata);
				errors++;
			end else begin
				oldest = temps_due.pop_front();
				if (m_axis_tdata[15:0] !== oldest.room_air_temp) begin
					$error("room_air_temp: expected %0d, got %0d",
						oldest.room_air_temp, $signed(m_axis_tdata[15:0]));
					errors++;
				end
				if (m_axis_tdata[31:16] !== oldest.wall_temp) begin
					$error("wall_temp: expected %0d, got %0d",
						oldest.wall_temp, $signed(m_axis_tdata[31:16]));
					errors++;
				end
			end
		end
		m_axis_tready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	function automatic logic [31:0] rand_log(int unsigned max_bits);
		return $urandom >> $urandom_range(32 - max_bits, 31);
	endfunction

	function automatic logic [31:0] pick_reg(int unsigned max_bits);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		if (r < 16)
			return '1;
		if (r < 24)
			return $urandom;
		return rand_log(max_bits);
	endfunction

	function automatic tick_req_t make_req(bit rs, int dt, int duct, int mdot, int tout,
			int qoth, int tset);
		tick_req_t it;
		it.restart          = rs;
		it.step_time        = 16'(dt);
		it.duct_supply_temp = 16'(duct);
		it.mass_flow        = 20'(mdot);
		it.outside_temp     = 16'(tout);
		it.other_heat       = 21'(qoth);
		it.setpoint_temp    = 16'(tset);
		return it;
	endfunction

	// Mostly plausible room conditions; the rest is noise over the full field ranges.
	function automatic tick_req_t rand_req();
		tick_req_t it;
		if ($urandom_range(0, 99) < 20) begin
			it.restart          = 1'($urandom);
			it.step_time        = 16'($urandom);
			it.duct_supply_temp = 16'($urandom);
			it.mass_flow        = 20'($urandom);
			it.outside_temp     = 16'($urandom);
			it.other_heat       = 21'($urandom);
			it.setpoint_temp    = 16'($urandom);
		end else begin
			it.restart          = ($urandom_range(0, 99) < 8);
			it.step_time        = 16'(rand_log(16));
			it.duct_supply_temp = 16'($urandom_range(10240, 32000));
			it.mass_flow        = 20'(rand_log(20));
			it.outside_temp     = 16'(int'($urandom_range(0, 40960)) - 10240);
			it.other_heat       = 21'(rand_log(20));
			if ($urandom_range(0, 1))
				it.other_heat = -it.other_heat;
			it.setpoint_temp    = 16'($urandom_range(12800, 23040));
		end
		return it;
	endfunction

	// Leaves tvalid high after the request is taken; the caller sends again or stops
	// in the same time step.
	task automatic send_step(tick_req_t it);
		int unsigned gap;
		gap = 0;
		if (idle_on)
			while ($urandom_range(0, 99) < IDLE_PCT)
				gap++;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= it.restart;
		s_axis_tdata  <= {7'd0, it.setpoint_temp, it.other_heat, it.outside_temp,
			it.mass_flow, it.duct_supply_temp, it.step_time};
		do @(posedge clk); while (!s_axis_tready);
		temps_due.push_back(advance_room(it));
	endtask

	task automatic wait_results_done();
		s_axis_tvalid <= 1'b0;
		while (temps_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic apply_config();
		cfg_idx_t idx;
		idx = idx.first();
		do begin
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= cfg_plan[idx];
			do @(posedge clk); while (!cfg_ready);
			cfg_regs[idx] = cfg_plan[idx];
			idx = idx.next();
		end while (idx != idx.first());
		cfg_valid <= 1'b0;
	endtask

	task automatic randomize_config();
		cfg_plan[CFG_AIR_CP]       = pick_reg(20);
		cfg_plan[CFG_CONV_GAIN]    = pick_reg(20);
		cfg_plan[CFG_HEAT_BIAS]    = pick_reg(28);
		if ($urandom_range(0, 1))
			cfg_plan[CFG_HEAT_BIAS] = -cfg_plan[CFG_HEAT_BIAS];
		cfg_plan[CFG_INV_AIR_CAP]  = pick_reg(14);
		cfg_plan[CFG_INV_WALL_CAP] = pick_reg(14);
		cfg_plan[CFG_INV_R_INNER]  = pick_reg(20);
		cfg_plan[CFG_INV_R_OUTER]  = pick_reg(20);
		cfg_plan[CFG_INNER_RATIO]  = pick_reg(17);
		apply_config();
	endtask

	// With the reset register values the reciprocals are zero, so both states freeze
	// except where a restart loads them.
	task automatic test_frozen_state();
		wait_results_done();
		send_step(make_req(0, 0, 0, 0, 0, 0, 0));
		send_step(make_req(0, 65535, 32767, 1048575, 0, 1048575, 0));
		send_step(make_req(1, 1024, 0, 0, 7680, 0, 17920));
		send_step(make_req(1, 1024, 0, 0, 23040, 0, 12800));
		send_step(make_req(1, 65535, 0, 0, 32767, 0, -32768));
		send_step(make_req(0, 65535, -32768, 1048575, -32768, -1048576, 32767));
	endtask

	task automatic test_field_extremes();
		wait_results_done();
		foreach (cfg_plan[i])
			cfg_plan[i] = '1;
		cfg_plan[CFG_HEAT_BIAS] = 32'h8000_0000;
		apply_config();
		send_step(make_req(1, 65535, 0, 0, -32768, 0, 32767));
		send_step(make_req(0, 65535, -32768, 1048575, 0, 1048575, 0));
		send_step(make_req(0, 1, 32767, 1, 32767, -1048576, 0));
		send_step(make_req(0, 0, 32767, 1048575, 0, 1048575, 0));
		wait_results_done();
		cfg_plan[CFG_HEAT_BIAS] = 32'h7FFF_FFFF;
		apply_config();
		send_step(make_req(0, 65535, 0, 0, 0, 0, 0));
		send_step(make_req(1, 65535, 0, 0, 32767, 0, -32768));
		send_step(make_req(0, 65535, 32767, 1048575, -32768, 1048575, 0));
	endtask

	// Inner ratio above one pushes the equilibrium wall past the outside temperature.
	task automatic test_restart_wall();
		wait_results_done();
		cfg_plan[CFG_AIR_CP]       = 32'd15729;
		cfg_plan[CFG_CONV_GAIN]    = 32'd3000;
		cfg_plan[CFG_HEAT_BIAS]    = 32'd200000;
		cfg_plan[CFG_INV_AIR_CAP]  = 32'd400;
		cfg_plan[CFG_INV_WALL_CAP] = 32'd40;
		cfg_plan[CFG_INV_R_INNER]  = 32'd90000;
		cfg_plan[CFG_INV_R_OUTER]  = 32'd60000;
		cfg_plan[CFG_INNER_RATIO]  = 32'h0003_0000;
		apply_config();
		send_step(make_req(1, 1024, 0, 0, 5120, 0, 18432));
		send_step(make_req(0, 4096, 25600, 40000, 5120, 3000, 18432));
		send_step(make_req(1, 1024, 0, 0, 24320, 0, 15360));
		send_step(make_req(0, 4096, 12800, 40000, 24320, -3000, 15360));
		send_step(make_req(1, 2048, 0, 0, 17920, 0, 17920));
	endtask

	task automatic test_random_ticks();
		tick_req_t it;
		int        s;
		int        k;
		for (s = 0; s < 5; s++) begin
			wait_results_done();
			randomize_config();
			it = rand_req();
			it.restart = 1'b1;
			send_step(it);
			for (k = 0; k < 70; k++) begin
				if (k == 35 || $urandom_range(0, 99) < 2)
					wait_results_done();
				send_step(rand_req());
			end
		end
	endtask

	task automatic test_no_idle_stretch();
		tick_req_t it;
		int        k;
		wait_results_done();
		idle_on = 1'b0;
		it = rand_req();
		it.restart = 1'b1;
		send_step(it);
		for (k = 0; k < 60; k++)
			send_step(rand_req());
		wait_results_done();
		idle_on = 1'b1;
	endtask

	initial begin
		foreach (cfg_regs[i])
			cfg_regs[i] = '0;
		cfg_regs[CFG_AIR_CP] = 32'd15729;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_frozen_state();
		test_field_extremes();
		test_restart_wall();
		test_random_ticks();
		test_no_idle_stretch();
		wait_results_done();
		repeat (80) @(posedge clk);
		if (temps_due.size() != 0) begin
			$error("%0d results never arrived", temps_due.size());
			errors++;
		end
		if (errors == 0)
			$display("PASS room_two_state_thermal_step");
		else
			$display("FAIL room_two_state_thermal_step");
		$finish;
	end

endmodule
